FILE: hdl/incremental_prefix_filter_top_defines.svh
// assertion macros for the incremental prefix filter
`ifndef INCREMENTAL_PREFIX_FILTER_TOP_DEFINES_SVH
`define INCREMENTAL_PREFIX_FILTER_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define IPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/ipf_pkg.sv
// shared types and constants of the incremental prefix filter
`default_nettype none
package ipf_pkg;

    localparam int ENTRIES_DEF  = 256;
    localparam int NAME_LEN_DEF = 64;

    localparam int CMD_W      = 2;
    localparam int IDX_W      = 8;
    localparam int POS_W      = 7;
    localparam int CH_W       = 8;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int ENTRY_COUNT_W = 9;
    localparam int MAX_PFX_W     = 7;
    localparam int MAX_ROWS_W    = 6;

    localparam logic [CH_W-1:0] CHAR_MIN = 8'd32;
    localparam logic [CH_W-1:0] CHAR_MAX = 8'd126;

    localparam logic [ENTRY_COUNT_W-1:0] ENTRY_COUNT_RST = 9'd0;
    localparam logic [MAX_PFX_W-1:0]     MAX_PFX_RST     = 7'd64;
    localparam logic [MAX_ROWS_W-1:0]    MAX_ROWS_RST    = 6'd20;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_TYPE  = 2'd1,
        CMD_ERASE = 2'd2,
        CMD_LIST  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK               = 3'd0,
        ST_FULL             = 3'd1,
        ST_NOT_PRINTABLE    = 3'd2,
        ST_NOTHING_TO_ERASE = 3'd3,
        ST_NO_MATCH         = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENTRY_COUNT = 2'd0,
        REG_MAX_PREFIX  = 2'd1,
        REG_MAX_ROWS    = 2'd2
    } t_reg;

    typedef struct packed {
        t_cmd cmd;
        logic active;
        logic load_hit;
        logic ch_eq;
        logic ch_zero;
    } t_sweep_ctl;

endpackage
`default_nettype wire

FILE: hdl/ipf_in_if.sv
// input channel: command beats
`default_nettype none
interface ipf_in_if import ipf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_index;
    logic [POS_W-1:0]  char_position;
    logic [CH_W-1:0]   character;

    modport source (output valid, command, entry_index, char_position, character,
                    input ready);
    modport sink   (input valid, command, entry_index, char_position, character,
                    output ready);
endinterface
`default_nettype wire

FILE: hdl/ipf_out_if.sv
// output channel: result beats
`default_nettype none
interface ipf_out_if import ipf_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    match_index;
    logic                match_valid;
    logic                last;

    modport source (output valid, status, match_index, match_valid, last, input ready);
    modport sink   (input valid, status, match_index, match_valid, last, output ready);
endinterface
`default_nettype wire

FILE: hdl/incremental_prefix_filter_top.sv
// Incremental prefix filter. Per-entry name and match lengths sit in a ring of
// ENTRIES cells that rotates one step a cycle, unless a list stalls on a busy
// output, past a single update stage; name characters sit in a memory of
// ENTRIES*NAME_LEN bytes read one entry ahead of the ring head. Every load, type,
// erase or list command that reaches the table takes one full turn of the ring,
// passing through the prep, sweep and finish states. A type refused as full or
// not printable and an erase at an empty prefix go straight to the finish state.
// A new command is taken only when the previous one is finished; a result beat
// may still wait in the output register.
`default_nettype none
`include "incremental_prefix_filter_top_defines.svh"
module incremental_prefix_filter_top import ipf_pkg::*; #(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int NAME_LEN = NAME_LEN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    ipf_in_if.sink                     i_in,
    ipf_out_if.source                  o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);
    localparam int LW        = $clog2(NAME_LEN + 1);
    localparam int CW        = $clog2(ENTRIES);
    localparam int MEM_DEPTH = ENTRIES * NAME_LEN;
    localparam int AW        = $clog2(MEM_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_PREP, S_SWEEP, S_FINISH} t_state;

    t_state                   r_state;
    t_cmd                     r_cmd;
    logic [IDX_W-1:0]         r_idx;
    logic [POS_W-1:0]         r_pos;
    logic [CH_W-1:0]          r_ch;
    logic [LW-1:0]            r_x;
    logic [LW-1:0]            r_prefix;
    logic [CW-1:0]            r_cnt;
    logic [MAX_ROWS_W-1:0]    r_count;
    logic                     r_done;
    logic                     r_pend_v;
    logic [CW-1:0]            r_pend;
    t_status                  r_fin_status;
    logic [ENTRY_COUNT_W-1:0] r_entry_count;
    logic [MAX_PFX_W-1:0]     r_max_pfx;
    logic [MAX_ROWS_W-1:0]    r_max_rows;
    logic [CH_W-1:0]          r_rd;
    logic [CH_W-1:0]          r_mem [MEM_DEPTH];

    logic                r_out_valid;
    t_status             r_status;
    logic [IDX_W-1:0]    r_out_idx;
    logic                r_mv;
    logic                r_last;

    logic [LW-1:0] cell_name  [ENTRIES];
    logic [LW-1:0] cell_match [ENTRIES];
    logic [LW-1:0] upd_name;
    logic [LW-1:0] upd_match;
    logic          upd_hit;
    t_sweep_ctl    ctl;

    int                    act_n;
    int                    cap;
    logic [MAX_ROWS_W-1:0] rows;
    logic                  active;
    logic                  load_ok;
    logic                  accept;
    logic                  out_free;
    logic                  list_hit;
    logic                  row_full;
    logic                  emit_need;
    logic                  stall;
    logic                  shift;
    logic                  last_ent;
    logic [CW-1:0]         rd_ent;
    logic [LW-1:0]         rd_x;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic                  wr_en;

    assign act_n    = (32'(r_entry_count) > ENTRIES) ? ENTRIES : 32'(r_entry_count);
    assign cap      = (32'(r_max_pfx) < NAME_LEN) ? 32'(r_max_pfx) : NAME_LEN;
    assign rows     = (r_max_rows == '0) ? MAX_ROWS_W'(1) : r_max_rows;
    assign active   = 32'(r_cnt) < act_n;
    assign load_ok  = 32'(r_idx) < ENTRIES && 32'(r_pos) <= NAME_LEN;
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign last_ent = 32'(r_cnt) == ENTRIES - 1;

    assign ctl.cmd      = r_cmd;
    assign ctl.active   = active;
    assign ctl.load_hit = load_ok && 32'(r_cnt) == 32'(r_idx);
    assign ctl.ch_eq    = r_rd == r_ch;
    assign ctl.ch_zero  = r_ch == '0;

    ipf_update #(.LW(LW)) u_update (
        .i_ctl   (ctl),
        .i_name  (cell_name[0]),
        .i_match (cell_match[0]),
        .i_x     (r_x),
        .o_name  (upd_name),
        .o_match (upd_match),
        .o_hit   (upd_hit)
    );

    assign list_hit  = r_state == S_SWEEP && r_cmd == CMD_LIST && !r_done && upd_hit;
    assign row_full  = ({1'b0, r_count} + 1'b1) == {1'b0, rows};
    assign emit_need = list_hit && r_pend_v;
    assign stall     = emit_need && !out_free;
    assign shift     = r_state == S_SWEEP && !stall;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_ring
            if (gi == ENTRIES - 1) begin : g_tail
                ipf_cell #(.LW(LW)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_name  (upd_name),
                    .i_match (upd_match),
                    .o_name  (cell_name[gi]),
                    .o_match (cell_match[gi])
                );
            end else begin : g_body
                ipf_cell #(.LW(LW)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_shift (shift),
                    .i_name  (cell_name[gi+1]),
                    .i_match (cell_match[gi+1]),
                    .o_name  (cell_name[gi]),
                    .o_match (cell_match[gi])
                );
            end
        end
    endgenerate

    // name character memory, read one entry ahead of the ring head
    always_comb begin
        if (r_state != S_SWEEP) rd_ent = '0;
        else if (stall)         rd_ent = r_cnt;
        else if (last_ent)      rd_ent = '0;
        else                    rd_ent = r_cnt + 1'b1;
    end
    assign rd_x    = (r_cmd == CMD_TYPE) ? r_x : '0;
    assign rd_addr = AW'(AW'(rd_ent) * AW'(NAME_LEN) + AW'(rd_x));
    assign wr_addr = AW'(AW'(i_in.entry_index) * AW'(NAME_LEN) + AW'(i_in.char_position));
    assign wr_en   = accept && i_in.command == CMD_LOAD
                     && 32'(i_in.entry_index) < ENTRIES
                     && 32'(i_in.char_position) < NAME_LEN;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= i_in.character;
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_prefix      <= '0;
            r_entry_count <= ENTRY_COUNT_RST;
            r_max_pfx     <= MAX_PFX_RST;
            r_max_rows    <= MAX_ROWS_RST;
            r_cnt         <= '0;
            r_count       <= '0;
            r_done        <= 1'b0;
            r_pend_v      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                    REG_MAX_PREFIX:  r_max_pfx     <= i_cfg_data[MAX_PFX_W-1:0];
                    REG_MAX_ROWS:    r_max_rows    <= i_cfg_data[MAX_ROWS_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd        <= t_cmd'(i_in.command);
                        r_idx        <= i_in.entry_index;
                        r_pos        <= i_in.char_position;
                        r_ch         <= i_in.character;
                        r_cnt        <= '0;
                        r_count      <= '0;
                        r_done       <= 1'b0;
                        r_pend_v     <= 1'b0;
                        r_fin_status <= ST_OK;
                        r_state      <= S_PREP;
                        case (t_cmd'(i_in.command))
                            CMD_LOAD: r_x <= LW'(i_in.char_position);
                            CMD_TYPE: begin
                                if (32'(r_prefix) >= cap) begin
                                    r_fin_status <= ST_FULL;
                                    r_state      <= S_FINISH;
                                end else if (i_in.character < CHAR_MIN
                                             || i_in.character > CHAR_MAX) begin
                                    r_fin_status <= ST_NOT_PRINTABLE;
                                    r_state      <= S_FINISH;
                                end else begin
                                    r_x      <= r_prefix;
                                    r_prefix <= r_prefix + 1'b1;
                                end
                            end
                            CMD_ERASE: begin
                                if (r_prefix == '0) begin
                                    r_fin_status <= ST_NOTHING_TO_ERASE;
                                    r_state      <= S_FINISH;
                                end else begin
                                    r_x      <= r_prefix - 1'b1;
                                    r_prefix <= r_prefix - 1'b1;
                                end
                            end
                            CMD_LIST: r_x <= r_prefix;
                            default: ;
                        endcase
                    end
                end
                S_PREP: r_state <= S_SWEEP;
                S_SWEEP: begin
                    if (!stall) begin
                        r_cnt <= r_cnt + 1'b1;
                        if (last_ent) r_state <= S_FINISH;
                        if (list_hit) begin
                            r_count <= r_count + 1'b1;
                            if (row_full) r_done <= 1'b1;
                            if (r_pend_v) begin
                                r_out_valid <= 1'b1;
                                r_status    <= ST_OK;
                                r_out_idx   <= IDX_W'(32'(r_pend));
                                r_mv        <= 1'b1;
                                r_last      <= 1'b0;
                            end
                            r_pend   <= r_cnt;
                            r_pend_v <= 1'b1;
                        end
                    end
                end
                S_FINISH: begin
                    if (r_cmd != CMD_LIST || r_fin_status != ST_OK) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_status    <= r_fin_status;
                            r_out_idx   <= '0;
                            r_mv        <= 1'b0;
                            r_last      <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else if (r_pend_v) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_OK;
                            r_out_idx   <= IDX_W'(32'(r_pend));
                            r_mv        <= 1'b1;
                            r_last      <= 1'b1;
                            r_pend_v    <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else if (r_count == '0) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_status    <= ST_NO_MATCH;
                            r_out_idx   <= '0;
                            r_mv        <= 1'b0;
                            r_last      <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = r_state == S_IDLE;
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.match_index = r_out_idx;
    assign o_out.match_valid = r_mv;
    assign o_out.last        = r_last;

    `IPF_ASSERT_NOW(a_match_ok, r_out_valid && r_mv, r_status == ST_OK, "match beat with bad status")
    `IPF_ASSERT_NOW(a_rows, r_state == S_SWEEP, r_count <= rows, "list passed row limit")
    `IPF_ASSERT_NEXT(a_erase, accept && i_in.command == CMD_ERASE && r_prefix != '0, r_prefix == LW'($past(r_prefix) - 1'b1), "erase did not shorten prefix")

endmodule
`default_nettype wire

FILE: hdl/ipf_cell.sv
// one ring cell: name length and match length of one entry
`default_nettype none
module ipf_cell import ipf_pkg::*; #(
    parameter int LW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire logic [LW-1:0] i_name,
    input  wire logic [LW-1:0] i_match,
    output logic      [LW-1:0] o_name,
    output logic      [LW-1:0] o_match
);
    logic [LW-1:0] r_name;
    logic [LW-1:0] r_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name  <= '0;
            r_match <= '0;
        end else if (i_shift) begin
            r_name  <= i_name;
            r_match <= i_match;
        end
    end

    assign o_name  = r_name;
    assign o_match = r_match;
endmodule
`default_nettype wire

FILE: hdl/ipf_update.sv
// per-entry update applied at the head of the ring
`default_nettype none
module ipf_update import ipf_pkg::*; #(
    parameter int LW = 7
) (
    input  wire t_sweep_ctl    i_ctl,
    input  wire logic [LW-1:0] i_name,
    input  wire logic [LW-1:0] i_match,
    input  wire logic [LW-1:0] i_x,
    output logic      [LW-1:0] o_name,
    output logic      [LW-1:0] o_match,
    output logic               o_hit
);
    always_comb begin
        o_name  = i_name;
        o_match = i_match;
        o_hit   = 1'b0;
        case (i_ctl.cmd)
            CMD_LOAD: begin
                if (i_ctl.load_hit) begin
                    if (i_ctl.ch_zero) o_name = i_x;
                    if (i_match > i_x) o_match = i_x;
                end
            end
            CMD_TYPE: begin
                if (i_ctl.active && i_match != i_name && i_match == i_x && i_ctl.ch_eq)
                    o_match = i_x + 1'b1;
            end
            CMD_ERASE: begin
                if (i_ctl.active && i_match > i_x) o_match = i_x;
            end
            CMD_LIST: begin
                o_hit = i_ctl.active && i_match == i_x;
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
